// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the prefix count table modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/dpct_pkg.sv
// -----------------------------------------------------------------------------
// dpct_pkg
// Types, constants and helpers shared by the prefix count table modules.
// -----------------------------------------------------------------------------
package dpct_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 4096;
	localparam int COUNT_WIDTH = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

	// Item field widths.
	localparam int OP_W  = 3;
	localparam int POS_W = 13;
	localparam int AMT_W = 16;
	localparam int ERR_W = 2;

	// Width that holds a size plus an amount without wrapping.
	localparam int EXT_W = ((SIZE_W > AMT_W) ? SIZE_W : AMT_W) + 1;

	// Stream widths, padded to whole bytes.
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 3'd0,
		OP_APPEND = 3'd1,
		OP_RANK   = 3'd2,
		OP_CLAMP  = 3'd3,
		OP_INC    = 3'd4,
		OP_DEC    = 3'd5,
		OP_INSERT = 3'd6
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START_WR,
		ST_APP_RD,
		ST_APP_WR,
		ST_RANK_RD,
		ST_RANK_CAP,
		ST_UPD_RUN,
		ST_INS_FILL_RD,
		ST_INS_FILL_CAP,
		ST_INS_SHIFT,
		ST_INS_FILL,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic check;
		logic start_wr;
		logic app_rd;
		logic app_wr;
		logic rank_rd;
		logic rank_cap;
		logic upd_issue;
		logic fill_rd;
		logic fill_cap;
		logic shift_issue;
		logic fill_wr;
		logic ins_done;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic err_any;
		logic amt_zero;
		logic scan_up_done;
		logic scan_dn_done;
		logic wr_pend;
		logic fill_done;
		logic out_free;
	} stat_t;

	// Addition that sticks at the largest count.
	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
	endfunction

endpackage

// File: rtl/dpct_ram.sv
// -----------------------------------------------------------------------------
// dpct_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// -----------------------------------------------------------------------------
module dpct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/dpct_datapath.sv
// -----------------------------------------------------------------------------
// dpct_datapath
// Item registers, table memory, scan counters, range checks and the output
// register of the prefix count table.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpct_datapath
	import dpct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  st,
	input  op_t                    in_op,
	input  logic [POS_W-1:0]       in_pos,
	input  logic                   in_bit,
	input  logic [AMT_W-1:0]       in_amt,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COUNT_WIDTH-1:0] out_count,
	output err_t                   out_err,
	output logic [SIZE_W-1:0]      out_size
);

	// Latched item.
	op_t              op_q;
	logic [POS_W-1:0] pos_q;
	logic             bit_q;
	logic [AMT_W-1:0] amt_q;

	// Table state and per-item working registers.
	logic [SIZE_W-1:0]      used_q;
	err_t                   err_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [SIZE_W-1:0]      idx_q;
	logic [COUNT_WIDTH-1:0] fill_q;
	logic [AMT_W-1:0]       fill_cnt_q;

	// Read-modify-write stage behind the memory read.
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	// Output register.
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	err_t                   out_err_q;
	logic [SIZE_W-1:0]      out_size_q;

	// Memory ports.
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	// Derived values.
	err_t                   chk_err;
	logic [EXT_W-1:0]       ins_total;
	logic [SIZE_W-1:0]      clamp_pos;
	logic [SIZE_W-1:0]      last_idx;
	logic [EXT_W-1:0]       shift_dst;
	logic [EXT_W-1:0]       fill_addr;
	logic [COUNT_WIDTH-1:0] upd_data;

	dpct_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sizes and addresses used by the checks and the scans.
	assign ins_total = EXT_W'(used_q) + EXT_W'(amt_q);
	assign last_idx  = used_q - SIZE_W'(1);
	assign clamp_pos = (SIZE_W'(pos_q) < used_q) ? SIZE_W'(pos_q) : last_idx;
	assign shift_dst = EXT_W'(idx_q) - EXT_W'(1) + EXT_W'(amt_q);
	assign fill_addr = EXT_W'(pos_q) + EXT_W'(fill_cnt_q);

	// Range and capacity checks on the latched item.
	always_comb begin
		chk_err = ERR_OK;
		unique case (op_q) inside
			OP_APPEND: begin
				if (used_q == '0) begin
					chk_err = ERR_RANGE;
				end else if (used_q >= SIZE_W'(TABLE_DEPTH)) begin
					chk_err = ERR_FULL;
				end
			end
			OP_RANK: begin
				if (SIZE_W'(pos_q) >= used_q) begin
					chk_err = ERR_RANGE;
				end
			end
			OP_CLAMP: begin
				if (used_q == '0) begin
					chk_err = ERR_RANGE;
				end
			end
			OP_INC, OP_DEC: begin
				if (SIZE_W'(pos_q) > used_q) begin
					chk_err = ERR_RANGE;
				end
			end
			OP_INSERT: begin
				if (SIZE_W'(pos_q) > used_q) begin
					chk_err = ERR_RANGE;
				end else if (ins_total > EXT_W'(TABLE_DEPTH)) begin
					chk_err = ERR_FULL;
				end
			end
			default: begin
				chk_err = ERR_OK;
			end
		endcase
	end

	// New value of an entry in a range update or a shift.
	always_comb begin
		case (op_q)
			OP_INC:  upd_data = sat_add(ram_rdata, COUNT_WIDTH'(amt_q));
			OP_DEC:  upd_data = (ram_rdata > COUNT_WIDTH'(amt_q)) ?
			                    ram_rdata - COUNT_WIDTH'(amt_q) : '0;
			default: upd_data = ram_rdata;
		endcase
	end

	// Memory read port.
	always_comb begin
		ram_re    = cmd.app_rd | cmd.rank_rd | cmd.upd_issue | cmd.fill_rd |
		            cmd.shift_issue;
		ram_raddr = idx_q[ADDR_W-1:0];
		if (cmd.app_rd) begin
			ram_raddr = last_idx[ADDR_W-1:0];
		end else if (cmd.rank_rd) begin
			ram_raddr = (op_q == OP_RANK) ? pos_q[ADDR_W-1:0] : clamp_pos[ADDR_W-1:0];
		end else if (cmd.fill_rd) begin
			ram_raddr = ADDR_W'(pos_q - POS_W'(1));
		end else if (cmd.shift_issue) begin
			ram_raddr = ADDR_W'(idx_q - SIZE_W'(1));
		end
	end

	// Memory write port.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_s1;
		ram_wdata = upd_data;
		if (cmd.start_wr) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = '0;
		end else if (cmd.app_wr) begin
			ram_we    = 1'b1;
			ram_waddr = used_q[ADDR_W-1:0];
			ram_wdata = sat_add(ram_rdata, COUNT_WIDTH'(bit_q));
		end else if (cmd.fill_wr) begin
			ram_we    = 1'b1;
			ram_waddr = fill_addr[ADDR_W-1:0];
			ram_wdata = fill_q;
		end else if (wr_pend_s1) begin
			ram_we = 1'b1;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_op;
			pos_q <= in_pos;
			bit_q <= in_bit;
			amt_q <= in_amt;
		end
	end

	// Number of valid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.start_wr) begin
			used_q <= SIZE_W'(1);
		end else if (cmd.app_wr) begin
			used_q <= used_q + SIZE_W'(1);
		end else if (cmd.ins_done) begin
			used_q <= ins_total[SIZE_W-1:0];
		end
	end

	// Result code, read count, scan index and fill value.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			err_q <= chk_err;
			cnt_q <= '0;
			idx_q <= SIZE_W'(pos_q);
		end
		if (cmd.rank_cap) begin
			cnt_q <= ram_rdata;
		end
		if (cmd.upd_issue) begin
			idx_q <= idx_q + SIZE_W'(1);
		end
		if (cmd.fill_rd) begin
			idx_q <= used_q;
		end
		if (cmd.shift_issue) begin
			idx_q <= idx_q - SIZE_W'(1);
		end
		if (cmd.fill_cap) begin
			fill_q     <= (pos_q == '0) ? '0 : ram_rdata;
			fill_cnt_q <= '0;
		end
		if (cmd.fill_wr) begin
			fill_cnt_q <= fill_cnt_q + AMT_W'(1);
		end
	end

	// Write-back stage for updates and shifts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.upd_issue | cmd.shift_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_issue) begin
			wr_addr_s1 <= idx_q[ADDR_W-1:0];
		end else if (cmd.shift_issue) begin
			wr_addr_s1 <= shift_dst[ADDR_W-1:0];
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_count_q <= cnt_q;
			out_err_q   <= err_q;
			out_size_q  <= used_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_count = out_count_q;
	assign out_err   = out_err_q;
	assign out_size  = out_size_q;

	// Status for the controller.
	assign st.op           = op_q;
	assign st.err_any      = (chk_err != ERR_OK);
	assign st.amt_zero     = (amt_q == '0);
	assign st.scan_up_done = (idx_q == used_q);
	assign st.scan_dn_done = (idx_q == SIZE_W'(pos_q));
	assign st.wr_pend      = wr_pend_s1;
	assign st.fill_done    = (fill_cnt_q == amt_q);
	assign st.out_free     = !out_valid_q || out_ready;

	// The table never holds more entries than the memory has.
	`ASSERT_PROP(a_used_in_range, clk, arst_n, used_q <= SIZE_W'(TABLE_DEPTH),
		"table size exceeds memory depth")

	// A fill write must never collide with a pending write-back.
	`ASSERT_NEVER(a_no_write_clash, clk, arst_n, wr_pend_s1 && cmd.fill_wr,
		"fill write collides with pending write-back")

	// The table size changes only through start, append or insert.
	`ASSERT_PROP(a_size_change, clk, arst_n,
		!$stable(used_q) |-> ($past(cmd.start_wr) || $past(cmd.app_wr) ||
		$past(cmd.ins_done)), "table size changed without a command")

endmodule

// File: rtl/dpct_ctrl.sv
// -----------------------------------------------------------------------------
// dpct_ctrl
// Controller state machine of the prefix count table: sequences reads,
// scans and writes of one item and hands the result to the output register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpct_ctrl
	import dpct_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.err_any) begin
					state_d = ST_RESULT;
				end else begin
					unique case (st.op) inside
						OP_START:       state_d = ST_START_WR;
						OP_APPEND:      state_d = ST_APP_RD;
						OP_RANK, OP_CLAMP: state_d = ST_RANK_RD;
						OP_INC, OP_DEC: state_d = ST_UPD_RUN;
						OP_INSERT:      state_d = st.amt_zero ? ST_RESULT : ST_INS_FILL_RD;
						default:        state_d = ST_RESULT;
					endcase
				end
			end
			ST_START_WR:     state_d = ST_RESULT;
			ST_APP_RD:       state_d = ST_APP_WR;
			ST_APP_WR:       state_d = ST_RESULT;
			ST_RANK_RD:      state_d = ST_RANK_CAP;
			ST_RANK_CAP:     state_d = ST_RESULT;
			ST_UPD_RUN: begin
				if (st.scan_up_done && !st.wr_pend) begin
					state_d = ST_RESULT;
				end
			end
			ST_INS_FILL_RD:  state_d = ST_INS_FILL_CAP;
			ST_INS_FILL_CAP: state_d = ST_INS_SHIFT;
			ST_INS_SHIFT: begin
				if (st.scan_dn_done && !st.wr_pend) begin
					state_d = ST_INS_FILL;
				end
			end
			ST_INS_FILL: begin
				if (st.fill_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_CHECK:        cmd.check       = 1'b1;
			ST_START_WR:     cmd.start_wr    = 1'b1;
			ST_APP_RD:       cmd.app_rd      = 1'b1;
			ST_APP_WR:       cmd.app_wr      = 1'b1;
			ST_RANK_RD:      cmd.rank_rd     = 1'b1;
			ST_RANK_CAP:     cmd.rank_cap    = 1'b1;
			ST_UPD_RUN:      cmd.upd_issue   = !st.scan_up_done;
			ST_INS_FILL_RD:  cmd.fill_rd     = 1'b1;
			ST_INS_FILL_CAP: cmd.fill_cap    = 1'b1;
			ST_INS_SHIFT:    cmd.shift_issue = !st.scan_dn_done;
			ST_INS_FILL: begin
				cmd.fill_wr  = !st.fill_done;
				cmd.ins_done = st.fill_done;
			end
			ST_RESULT:       cmd.out_load    = st.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	// Every item is checked in the cycle after it is taken.
	`ASSERT_PROP(a_check_follows_load, clk, arst_n,
		cmd.load_in |=> state_q == ST_CHECK, "item taken but not checked")

	// A failed check goes straight to the result.
	`ASSERT_PROP(a_error_to_result, clk, arst_n,
		(state_q == ST_CHECK && st.err_any) |=> state_q == ST_RESULT,
		"failed item did not go straight to result")

	// A result is loaded only when the output register can take it.
	`ASSERT_PROP(a_load_when_free, clk, arst_n,
		cmd.out_load |-> st.out_free, "result loaded over an unread result")

endmodule

// File: rtl/dynamic_prefix_count_table.sv
// -----------------------------------------------------------------------------
// dynamic_prefix_count_table
// Rank table of running one-bit counts with append, queries, range updates
// and inserts, held in a single memory.
// -----------------------------------------------------------------------------
// Usage
// The slave stream takes one command item per handshake: tuser carries the
// operation, tdata the position, the appended bit and the amount. The master
// stream returns exactly one result item per command: tdata carries the count
// read and the table size afterwards, tuser the error code.
// Items are worked one at a time. A failed command, an unused code or an empty
// insert goes straight to the result; start writes the first entry, append
// reads the last entry and writes the next, and rank queries read one entry.
// Increase and decrease update each entry from the position to the table end;
// insert moves the entries from the position upward, then writes the new entries.
// The scans are set by the single write port of the table memory.
// The result is valid from the next cycle, when the next item is also taken,
// so a receiver that stalls holds at most one result and then stops the
// slave side. Reset empties the table at once; the memory needs no clearing.
// -----------------------------------------------------------------------------
module dynamic_prefix_count_table
	import dpct_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// pos [12:0], bit_in [13], amount [29:14], zero [31:30]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	// op [2:0]
	input  logic [OP_W-1:0]     s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// count_out [15:0], table_size [28:16], zero [31:29]
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// error_code [1:0]
	output logic [ERR_W-1:0]    m_axis_tuser
);

	cmd_t                   cmd;
	stat_t                  st;
	logic [COUNT_WIDTH-1:0] out_count;
	err_t                   out_err;
	logic [SIZE_W-1:0]      out_size;

	dpct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	dpct_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (op_t'(s_axis_tuser)),
		.in_pos    (s_axis_tdata[POS_W-1:0]),
		.in_bit    (s_axis_tdata[POS_W]),
		.in_amt    (s_axis_tdata[POS_W+1 +: AMT_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_count (out_count),
		.out_err   (out_err),
		.out_size  (out_size)
	);

	// Result packing, lowest field first.
	assign m_axis_tdata = {{(M_DATA_W - COUNT_WIDTH - SIZE_W){1'b0}}, out_size, out_count};
	assign m_axis_tuser = out_err;

endmodule

// File: tb/dynamic_prefix_count_table_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dynamic_prefix_count_table_tb
// Self-checking bench for the rank table. Command items go in on the slave
// stream and every accepted item is run through a shadow copy of the table to
// predict its result. Each result item is compared field by field with the
// oldest prediction. A directed part covers the edge cases and a random part
// covers mostly well-formed command sequences, with random stalls on both sides.
// -----------------------------------------------------------------------------
module dynamic_prefix_count_table_tb;
	import dpct_pkg::*;

	// Opcode that the block leaves unused.
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
	localparam int QUIET_LIMIT = 50000;

	typedef struct {
		logic [COUNT_WIDTH-1:0] count;
		err_t                   err;
		logic [SIZE_W-1:0]      size;
	} table_result_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// pos [12:0], bit_in [13], amount [29:14], zero [31:30]
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	// op [2:0]
	logic [OP_W-1:0]     s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// count_out [15:0], table_size [28:16], zero [31:29]
	logic [M_DATA_W-1:0] m_axis_tdata;
	// error_code [1:0]
	logic [ERR_W-1:0]    m_axis_tuser;

	// Shadow copy of the table, updated as each command item is accepted.
	logic [COUNT_WIDTH-1:0] shadow_counts [TABLE_DEPTH];
	int                     shadow_used = 0;
	table_result_t          awaited_results [$];

	int mismatches      = 0;
	int commands_sent   = 0;
	int results_checked = 0;
	int quiet_cycles    = 0;
	int hold_request    = 0;
	int hold_left       = 0;
	bit steady_flow     = 1'b0;

	wire command_taken = s_axis_tvalid && s_axis_tready;
	wire result_taken  = m_axis_tvalid && m_axis_tready;

	dynamic_prefix_count_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Addition that sticks at the largest count.
	function automatic logic [COUNT_WIDTH-1:0] add_clipped(input int a, input int b);
		int total;
		total = a + b;
		return (total > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX) : COUNT_WIDTH'(total);
	endfunction

	// Applies one command to the shadow table and returns the result it yields.
	function automatic table_result_t next_table_result(input logic [OP_W-1:0] op,
		input logic [POS_W-1:0] pos, input logic bit_in, input logic [AMT_W-1:0] amount);
		table_result_t          r;
		logic [COUNT_WIDTH-1:0] fill;
		r.count = '0;
		r.err   = ERR_OK;
		case (op)
			OP_START: begin
				shadow_counts[0] = '0;
				shadow_used      = 1;
			end
			OP_APPEND: begin
				if (shadow_used == 0) begin
					r.err = ERR_RANGE;
				end else if (shadow_used >= TABLE_DEPTH) begin
					r.err = ERR_FULL;
				end else begin
					shadow_counts[shadow_used] = add_clipped(shadow_counts[shadow_used - 1],
						bit_in);
					shadow_used++;
				end
			end
			OP_RANK: begin
				if (pos >= shadow_used)
					r.err = ERR_RANGE;
				else
					r.count = shadow_counts[pos];
			end
			OP_CLAMP: begin
				if (shadow_used == 0)
					r.err = ERR_RANGE;
				else
					r.count = shadow_counts[(pos < shadow_used) ? int'(pos) : shadow_used - 1];
			end
			OP_INC: begin
				if (pos > shadow_used)
					r.err = ERR_RANGE;
				else
					for (int i = pos; i < shadow_used; i++)
						shadow_counts[i] = add_clipped(shadow_counts[i], amount);
			end
			OP_DEC: begin
				if (pos > shadow_used)
					r.err = ERR_RANGE;
				else
					for (int i = pos; i < shadow_used; i++)
						shadow_counts[i] = (shadow_counts[i] > amount) ?
							shadow_counts[i] - amount : '0;
			end
			OP_INSERT: begin
				if (pos > shadow_used) begin
					r.err = ERR_RANGE;
				end else if (shadow_used + int'(amount) > TABLE_DEPTH) begin
					r.err = ERR_FULL;
				end else if (amount != 0) begin
					// The fill value is the entry just below the gap, zero at the bottom.
					fill = (pos > 0) ? shadow_counts[pos - 1] : '0;
					for (int i = shadow_used - 1; i >= int'(pos); i--)
						shadow_counts[i + amount] = shadow_counts[i];
					for (int i = 0; i < amount; i++)
						shadow_counts[pos + i] = fill;
					shadow_used += int'(amount);
				end
			end
			default: begin
			end
		endcase
		r.size = SIZE_W'(shadow_used);
		return r;
	endfunction

	// Predicts on each accepted command item and checks each result item.
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && command_taken)
			awaited_results.insert(awaited_results.size(),
				next_table_result(s_axis_tuser,
				s_axis_tdata[POS_W-1:0], s_axis_tdata[POS_W],
				s_axis_tdata[POS_W+1 +: AMT_W]));
		if (arst_n && result_taken) begin
			results_checked++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result item with nothing expected, data %h, error %0d",
					$time, m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (m_axis_tdata[COUNT_WIDTH-1:0] !== want.count) begin
					$display("%0t: count_out expected %0d, actual %0d", $time,
						want.count, m_axis_tdata[COUNT_WIDTH-1:0]);
					mismatches++;
				end
				if (m_axis_tuser !== want.err) begin
					$display("%0t: error_code expected %0d, actual %0d", $time,
						want.err, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[COUNT_WIDTH +: SIZE_W] !== want.size) begin
					$display("%0t: table_size expected %0d, actual %0d", $time,
						want.size, m_axis_tdata[COUNT_WIDTH +: SIZE_W]);
					mismatches++;
				end
			end
		end
	end

	// Result receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady_flow || ($urandom_range(99) >= 28);
		end
	end

	// Watchdog on cycles in which neither stream moves an item.
	always @(posedge clk) begin
		if (!arst_n || command_taken || result_taken)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offers one command item until it is taken, after a random gap unless the flow is steady.
	task automatic send_command(input logic [OP_W-1:0] op, input int pos,
		input logic bit_in, input int amount);
		while (!steady_flow && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= S_DATA_W'({AMT_W'(amount), bit_in, POS_W'(pos)});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		commands_sent++;
	endtask

	// Stops offering items until every result has come back.
	task automatic wait_until_drained;
		s_axis_tvalid <= 1'b0;
		while (results_checked < commands_sent)
			@(posedge clk);
	endtask

	// One random command, mostly well formed and on a small table.
	task automatic send_random_command;
		int               pick;
		int               used;
		int               pos;
		int               amount;
		logic [OP_W-1:0]  op;
		used   = shadow_used;
		pick   = $urandom_range(99);
		amount = $urandom_range(1) ? $urandom_range(COUNT_MAX) : $urandom_range(300);
		pos    = ($urandom_range(9) == 0) ? $urandom_range(TABLE_DEPTH) : $urandom_range(used);
		if (used == 0 || used > 64 || pick < 6)
			op = OP_START;
		else if (pick < 40)
			op = (used < 48) ? OP_APPEND : OP_RANK;
		else if (pick < 55)
			op = OP_RANK;
		else if (pick < 65)
			op = OP_CLAMP;
		else if (pick < 75)
			op = OP_INC;
		else if (pick < 83)
			op = OP_DEC;
		else if (pick < 96)
			op = OP_INSERT;
		else
			op = OP_UNUSED;
		// Inserts stay small, apart from some that must overflow the table.
		if (op == OP_INSERT)
			amount = ($urandom_range(7) == 0) ? $urandom_range(COUNT_MAX, TABLE_DEPTH + 1) :
				$urandom_range(6);
		send_command(op, pos, 1'($urandom_range(1)), amount);
	endtask

	// Each command but start and decrease on a table that has not been started.
	task automatic test_empty_table;
		send_command(OP_APPEND, 0, 1'b1, 0);
		send_command(OP_RANK, 0, 1'b0, 0);
		send_command(OP_CLAMP, TABLE_DEPTH, 1'b0, 0);
		send_command(OP_INSERT, 1, 1'b0, 1);
		send_command(OP_UNUSED, 0, 1'b1, COUNT_MAX);
		send_command(OP_INC, 0, 1'b0, 7);
		wait_until_drained();
	endtask

	// Builds the table 0, 1, 1, 2 and queries its last entry, past its end and clamped.
	task automatic test_append_and_query;
		send_command(OP_START, 0, 1'b0, 0);
		send_command(OP_APPEND, 0, 1'b1, 0);
		send_command(OP_APPEND, 0, 1'b0, 0);
		send_command(OP_APPEND, 0, 1'b1, 0);
		send_command(OP_RANK, 3, 1'b0, 0);
		send_command(OP_RANK, 4, 1'b0, 0);
		send_command(OP_CLAMP, TABLE_DEPTH, 1'b0, 0);
		wait_until_drained();
	endtask

	// Saturation and updates at and past the table end.
	task automatic test_range_updates;
		send_command(OP_INC, 1, 1'b0, COUNT_MAX);
		send_command(OP_APPEND, 0, 1'b1, 0);
		send_command(OP_DEC, 2, 1'b0, 16'h5555);
		send_command(OP_INC, 5, 1'b0, 3);
		send_command(OP_DEC, 6, 1'b0, 1);
		send_command(OP_RANK, 2, 1'b0, 0);
		wait_until_drained();
	endtask

	// Inserts at the bottom, in the middle, at the end, empty and too large.
	task automatic test_insert;
		send_command(OP_INSERT, 0, 1'b0, 2);
		send_command(OP_INSERT, 4, 1'b0, 3);
		send_command(OP_INSERT, 10, 1'b0, 1);
		send_command(OP_INSERT, 3, 1'b0, 0);
		send_command(OP_INSERT, 0, 1'b0, COUNT_MAX);
		wait_until_drained();
	endtask

	// Fills the table to its last entry and tries to grow it further.
	task automatic test_full_table;
		send_command(OP_START, 0, 1'b0, 0);
		send_command(OP_INSERT, 0, 1'b0, TABLE_DEPTH - 1);
		send_command(OP_APPEND, 0, 1'b1, 0);
		send_command(OP_INSERT, TABLE_DEPTH, 1'b0, 1);
		send_command(OP_RANK, TABLE_DEPTH - 1, 1'b0, 0);
		wait_until_drained();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_command();
		wait_until_drained();
	endtask

	// Neither side idles for the whole stretch.
	task automatic test_steady_stream(input int count);
		steady_flow = 1'b1;
		repeat (count) send_random_command();
		wait_until_drained();
		steady_flow = 1'b0;
	endtask

	// The receiver holds off while items keep coming, so the input stalls.
	task automatic test_output_backpressure(input int count);
		hold_request = 400;
		repeat (count) send_random_command();
		wait_until_drained();
	endtask

	// Test sequence.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_append_and_query();
		test_range_updates();
		test_insert();
		test_full_table();
		test_random_mix(70);
		test_steady_stream(30);
		test_output_backpressure(12);
		wait_until_drained();
		repeat (20) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				awaited_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: dynamic_prefix_count_table.f
+incdir+rtl
rtl/dpct_pkg.sv
rtl/dpct_ram.sv
rtl/dpct_datapath.sv
rtl/dpct_ctrl.sv
rtl/dynamic_prefix_count_table.sv
tb/dynamic_prefix_count_table_tb.sv
